[src/tfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_pkg: shared types and constants of the texel format converter
// Source format codes, the queue entry that links the front and back parts,
// and the field expansion tables.
// ----------------------------------------------------------------------------
package tfr_pkg;

	typedef enum logic [2:0] {
		FMT_RGBA32 = 3'd0,
		FMT_RGBA16 = 3'd1,
		FMT_IA1    = 3'd2,
		FMT_IA4    = 3'd3,
		FMT_IA8    = 3'd4,
		FMT_IA16   = 3'd5,
		FMT_I4     = 3'd6,
		FMT_I8     = 3'd7
	} fmt_t;

	// Depth of the queue between front and back.
	localparam int unsigned QDepth  = 2;
	localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int unsigned QCountW = $clog2(QDepth + 1);

	// One assembled texel word ready for expansion.
	typedef struct packed {
		logic [31:0] word;
		fmt_t        fmt;
	} job_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [QCountW-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_of_run;
	} pixel_t;

	// floor(v * 255 / 31)
	localparam logic [7:0] Exp5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	// floor(v * 255 / 7)
	localparam logic [7:0] Exp3 [8] = '{
		8'd0, 8'd36, 8'd72, 8'd109, 8'd145, 8'd182, 8'd218, 8'd255
	};

	// Index of the final pixel that one queue entry expands to.
	function automatic logic [2:0] last_index(input fmt_t fmt);
		logic [2:0] r;
		unique case (fmt)
			FMT_IA1:         r = 3'd7;
			FMT_IA4, FMT_I4: r = 3'd1;
			default:         r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

[src/tfr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_if: channel interfaces of the texel format converter
// Byte input channel, pixel output channel and format register write channel.
// ----------------------------------------------------------------------------
interface tfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface tfr_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       last_of_run;

	modport source (output valid, red, green, blue, alpha, last_of_run, input ready);
	modport sink   (input valid, red, green, blue, alpha, last_of_run, output ready);
endinterface

interface tfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] source_format;

	modport source (output valid, source_format, input ready);
	modport sink   (input valid, source_format, output ready);
endinterface

[src/tfr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_front: byte intake and texel assembly
// Holds the format register, gathers the bytes of multi-byte texels and
// pushes one queue entry per byte that yields at least one pixel.
// ----------------------------------------------------------------------------
module tfr_front (
	input  logic             clk,
	input  logic             arst_n,
	tfr_byte_if.sink         in_ch,
	tfr_cfg_if.sink          cfg,
	input  tfr_pkg::q_stat_t q_stat,
	output logic             q_push,
	output tfr_pkg::job_t    q_job
);

	tfr_pkg::fmt_t fmt_q;
	logic [23:0]   held_q;
	logic [1:0]    phase_q;
	logic          accept;
	logic          emit;
	logic [23:0]   held_d;
	logic [1:0]    phase_d;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		emit       = 1'b1;
		held_d     = held_q;
		phase_d    = phase_q;
		q_job.fmt  = fmt_q;
		q_job.word = {24'd0, in_ch.data_byte};
		unique case (fmt_q)
			tfr_pkg::FMT_RGBA32: begin
				if (phase_q == 2'd3) begin
					q_job.word = {held_q, in_ch.data_byte};
					held_d     = '0;
					phase_d    = '0;
				end else begin
					emit    = 1'b0;
					held_d  = {held_q[15:0], in_ch.data_byte};
					phase_d = phase_q + 2'd1;
				end
			end
			tfr_pkg::FMT_RGBA16, tfr_pkg::FMT_IA16: begin
				if (phase_q != 2'd0) begin
					q_job.word = {16'd0, held_q[7:0], in_ch.data_byte};
					held_d     = '0;
					phase_d    = '0;
				end else begin
					emit    = 1'b0;
					held_d  = {16'd0, in_ch.data_byte};
					phase_d = 2'd1;
				end
			end
			default: begin
			end
		endcase
		if (in_ch.last_byte) begin
			held_d  = '0;
			phase_d = '0;
		end
	end

	assign q_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= tfr_pkg::FMT_RGBA32;
			held_q  <= '0;
			phase_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			fmt_q   <= tfr_pkg::fmt_t'(cfg.source_format);
			held_q  <= '0;
			phase_q <= '0;
		end else if (accept) begin
			held_q  <= held_d;
			phase_q <= phase_d;
		end
	end

endmodule

[src/tfr_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_fifo: short queue between the front and back parts
// A small register queue of assembled texel words with count-based status.
// ----------------------------------------------------------------------------
module tfr_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tfr_pkg::job_t     push_job,
	input  logic              pop,
	output tfr_pkg::job_t     head_job,
	output tfr_pkg::q_stat_t  stat
);

	tfr_pkg::job_t                   mem_q [tfr_pkg::QDepth];
	logic [tfr_pkg::QPtrW-1:0]       wr_ptr_q;
	logic [tfr_pkg::QPtrW-1:0]       rd_ptr_q;
	logic [tfr_pkg::QCountW-1:0]     count_q;

	localparam logic [tfr_pkg::QPtrW-1:0]   PtrLast = tfr_pkg::QPtrW'(tfr_pkg::QDepth - 1);
	localparam logic [tfr_pkg::QCountW-1:0] CntFull = tfr_pkg::QCountW'(tfr_pkg::QDepth);

	assign stat.count = count_q;
	assign stat.full  = (count_q == CntFull);
	assign stat.empty = (count_q == '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/tfr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_back: pixel expansion and output register
// Walks the pixels of the head entry, one per cycle unless the output stalls,
// expands each field to eight bits and holds the pixel in the output register.
// ----------------------------------------------------------------------------
module tfr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tfr_pkg::job_t    head_job,
	input  tfr_pkg::q_stat_t q_stat,
	output logic             q_pop,
	tfr_pixel_if.source      out_ch
);

	logic [2:0]      idx_q;
	logic            out_valid_q;
	tfr_pkg::pixel_t pix_q;
	tfr_pkg::pixel_t pix_d;
	logic            advance;
	logic            take;
	logic            at_last;
	logic [3:0]      nib;
	logic [7:0]      w8;
	logic [15:0]     w16;
	logic [7:0]      inten;
	logic [7:0]      alpha;

	assign advance = !out_valid_q || out_ch.ready;
	assign take    = advance && !q_stat.empty;
	assign at_last = (idx_q == tfr_pkg::last_index(head_job.fmt));
	assign q_pop   = take && at_last;

	assign w8  = head_job.word[7:0];
	assign w16 = head_job.word[15:0];
	// First pixel of a byte comes from the high nibble.
	assign nib = (idx_q[0] == 1'b0) ? w8[7:4] : w8[3:0];

	always_comb begin
		inten = w8;
		alpha = 8'hFF;
		pix_d.last_of_run = at_last;
		unique case (head_job.fmt)
			tfr_pkg::FMT_RGBA32: begin
				inten = head_job.word[31:24];
				alpha = head_job.word[7:0];
			end
			tfr_pkg::FMT_RGBA16: begin
				inten = tfr_pkg::Exp5[w16[15:11]];
				alpha = {8{w16[0]}};
			end
			tfr_pkg::FMT_IA1: begin
				inten = {8{w8[3'd7 - idx_q]}};
				alpha = {8{w8[3'd7 - idx_q]}};
			end
			tfr_pkg::FMT_IA4: begin
				inten = tfr_pkg::Exp3[nib[3:1]];
				alpha = {8{nib[0]}};
			end
			tfr_pkg::FMT_IA8: begin
				inten = {w8[7:4], w8[7:4]};
				alpha = {w8[3:0], w8[3:0]};
			end
			tfr_pkg::FMT_IA16: begin
				inten = w16[15:8];
				alpha = w16[7:0];
			end
			tfr_pkg::FMT_I4: begin
				inten = {nib, nib};
			end
			tfr_pkg::FMT_I8: begin
				inten = w8;
			end
			default: begin
			end
		endcase
		pix_d.red   = inten;
		pix_d.green = inten;
		pix_d.blue  = inten;
		pix_d.alpha = alpha;
		// The two color formats carry distinct green and blue fields.
		if (head_job.fmt == tfr_pkg::FMT_RGBA32) begin
			pix_d.green = head_job.word[23:16];
			pix_d.blue  = head_job.word[15:8];
		end else if (head_job.fmt == tfr_pkg::FMT_RGBA16) begin
			pix_d.green = tfr_pkg::Exp5[w16[10:6]];
			pix_d.blue  = tfr_pkg::Exp5[w16[5:1]];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_q <= pix_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_last ? 3'd0 : idx_q + 3'd1;
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.red         = pix_q.red;
	assign out_ch.green       = pix_q.green;
	assign out_ch.blue        = pix_q.blue;
	assign out_ch.alpha       = pix_q.alpha;
	assign out_ch.last_of_run = pix_q.last_of_run;

endmodule

[src/texel_format_to_rgba32_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_to_rgba32_top: packed texel stream to RGBA8888 converter
// Top level joining the byte intake, the entry queue and the pixel expander.
// ----------------------------------------------------------------------------
// The block takes one texture byte per beat and turns the stream into 8-bit
// RGBA pixels according to the source format register: rgba32 needs four
// bytes per pixel, rgba16 and ia16 two, ia8 and i8 one, ia4 and i4 yield two
// pixels per byte and ia1 eight. A byte is taken in every cycle while the
// two-entry queue between intake and expander has room, and the expander
// issues one pixel per cycle while the output side is not stalled, so the
// sustained rate is one byte per cycle for formats of at most one pixel per
// byte, and for ia4, i4 and ia1 the expander's single output port sets it.
// The byte that completes a pixel is registered in the queue, and the pixel
// then in the output register. last_of_run marks the final pixel caused by
// one byte. Writing the format register discards any partially assembled
// pixel; write it only while the block is idle.
module texel_format_to_rgba32_top (
	input  logic        clk,
	input  logic        arst_n,
	tfr_byte_if.sink    in_ch,
	tfr_cfg_if.sink     cfg,
	tfr_pixel_if.source out_ch
);

	tfr_pkg::q_stat_t q_stat;
	tfr_pkg::job_t    push_job;
	tfr_pkg::job_t    head_job;
	logic             q_push;
	logic             q_pop;

	// The front part assembles whole texels and hands them over as entries.
	tfr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.q_stat (q_stat),
		.q_push (q_push),
		.q_job  (push_job)
	);

	// The queue lets intake continue while the expander works through ia1.
	tfr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	// The back part expands the head entry pixel by pixel.
	tfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.out_ch   (out_ch)
	);

	// The intake must never push into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("queue push while full");

	// The expander must never retire an entry that is not there.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_stat.empty))
		else $error("queue pop while empty");

	// The occupancy rises by one after a push without a pop in the previous cycle.
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
		else $error("queue count did not follow a push");

endmodule

[dv/texel_format_to_rgba32_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_to_rgba32_top_test: self-checking bench of the texel converter
// Streams packed texture bytes in every source format, predicts the RGBA
// pixels each byte yields and compares them, beat by beat, with the output.
// ----------------------------------------------------------------------------

// Tracks the source format and the partly assembled pixel, and keeps the
// pixels that the accepted bytes are due to produce, oldest first.
class rgba_pixel_book;
	tfr_pkg::fmt_t   fmt;
	logic [23:0]     held;
	logic [1:0]      phase;
	tfr_pkg::pixel_t pending[$];
	int              errors;

	function new();
		fmt    = tfr_pkg::FMT_RGBA32;
		held   = '0;
		phase  = '0;
		errors = 0;
	endfunction

	// Any write of the register also throws away a partial pixel.
	function void set_format(tfr_pkg::fmt_t f);
		fmt   = f;
		held  = '0;
		phase = '0;
	endfunction

	// An n-bit field v widens to floor(v * 255 / (2^n - 1)).
	function logic [7:0] widen(int unsigned v, int unsigned n);
		return 8'((v * 255) / ((1 << n) - 1));
	endfunction

	function tfr_pkg::pixel_t make_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a);
		tfr_pkg::pixel_t p;
		p.red         = r;
		p.green       = g;
		p.blue        = b;
		p.alpha       = a;
		p.last_of_run = 1'b0;
		return p;
	endfunction

	function void note_byte(logic [7:0] b, logic last);
		tfr_pkg::pixel_t px[8];
		int              n;
		logic [31:0]     w;
		logic [3:0]      nib;
		logic [7:0]      v;
		n = 0;
		case (fmt)
			tfr_pkg::FMT_RGBA32: begin
				if (phase == 2'd3) begin
					w = {held, b};
					px[0] = make_px(w[31:24], w[23:16], w[15:8], w[7:0]);
					n = 1;
					held = '0;
					phase = '0;
				end else begin
					held = {held[15:0], b};
					phase = phase + 2'd1;
				end
			end
			tfr_pkg::FMT_RGBA16, tfr_pkg::FMT_IA16: begin
				if (phase != 2'd0) begin
					w = {16'h0000, held[7:0], b};
					if (fmt == tfr_pkg::FMT_RGBA16) begin
						px[0] = make_px(widen(w[15:11], 5), widen(w[10:6], 5),
							widen(w[5:1], 5), w[0] ? 8'hFF : 8'h00);
					end else begin
						px[0] = make_px(w[15:8], w[15:8], w[15:8], w[7:0]);
					end
					n = 1;
					held = '0;
					phase = '0;
				end else begin
					held = {16'h0000, b};
					phase = 2'd1;
				end
			end
			tfr_pkg::FMT_IA1: begin
				for (int i = 0; i < 8; i++) begin
					v = b[7 - i] ? 8'hFF : 8'h00;
					px[i] = make_px(v, v, v, v);
				end
				n = 8;
			end
			tfr_pkg::FMT_IA4: begin
				for (int i = 0; i < 2; i++) begin
					nib = (i == 0) ? b[7:4] : b[3:0];
					v = widen(nib[3:1], 3);
					px[i] = make_px(v, v, v, nib[0] ? 8'hFF : 8'h00);
				end
				n = 2;
			end
			tfr_pkg::FMT_IA8: begin
				v = b[7:4] * 8'd17;
				px[0] = make_px(v, v, v, b[3:0] * 8'd17);
				n = 1;
			end
			tfr_pkg::FMT_I4: begin
				for (int i = 0; i < 2; i++) begin
					nib = (i == 0) ? b[7:4] : b[3:0];
					v = nib * 8'd17;
					px[i] = make_px(v, v, v, 8'hFF);
				end
				n = 2;
			end
			default: begin
				px[0] = make_px(b, b, b, 8'hFF);
				n = 1;
			end
		endcase
		if (last) begin
			held = '0;
			phase = '0;
		end
		for (int i = 0; i < n; i++) begin
			if (i == n - 1) begin
				px[i].last_of_run = 1'b1;
			end
			pending.push_back(px[i]);
		end
	endfunction

	function void check_pixel(tfr_pkg::pixel_t got);
		tfr_pkg::pixel_t exp;
		if (pending.size() == 0) begin
			$error("pixel beat with nothing expected: r=%0d g=%0d b=%0d a=%0d",
				got.red, got.green, got.blue, got.alpha);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (got.red !== exp.red) begin
			$error("red: expected %0d, got %0d", exp.red, got.red);
			errors++;
		end
		if (got.green !== exp.green) begin
			$error("green: expected %0d, got %0d", exp.green, got.green);
			errors++;
		end
		if (got.blue !== exp.blue) begin
			$error("blue: expected %0d, got %0d", exp.blue, got.blue);
			errors++;
		end
		if (got.alpha !== exp.alpha) begin
			$error("alpha: expected %0d, got %0d", exp.alpha, got.alpha);
			errors++;
		end
		if (got.last_of_run !== exp.last_of_run) begin
			$error("last_of_run: expected %0d, got %0d", exp.last_of_run, got.last_of_run);
			errors++;
		end
	endfunction
endclass

module texel_format_to_rgba32_top_test;

	// Cycles to let pass once nothing is expected: room for the queue and
	// output registers plus a byte still sitting in the intake.
	localparam int SETTLE_CYCLES = 12;
	// Cycles without any beat on any channel before the run is abandoned.
	// The slowest legal stretch is a stall of the ready pattern or the
	// settle wait, far below this.
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASES        = 8;
	localparam int PHASE_BYTES   = 25;

	logic clk = 1'b0;
	logic arst_n;

	tfr_byte_if  in_ch();
	tfr_cfg_if   cfg();
	tfr_pixel_if out_ch();

	texel_format_to_rgba32_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.out_ch (out_ch)
	);

	rgba_pixel_book book = new();

	// Sender pacing: bursts of random length with random gaps, or no gaps.
	int            burst_left = 0;
	logic          gaps_on    = 1'b0;
	tfr_pkg::fmt_t cur_fmt    = tfr_pkg::FMT_RGBA32;

	// Receiver pacing: a 16-bit ready pattern walked by a free counter.
	logic [15:0] ready_mask = 16'hFFFF;
	logic [3:0]  ready_pos  = '0;
	int          quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		ready_pos    <= ready_pos + 4'd1;
		out_ch.ready <= arst_n && ready_mask[ready_pos];
	end

	// All three channels are sampled here, at the edge, with the values
	// seen by the block. Output is checked before the input of the same edge
	// is noted; a byte can never produce its pixel at the edge it enters.
	always @(posedge clk) begin
		tfr_pkg::pixel_t got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.red         = out_ch.red;
				got.green       = out_ch.green;
				got.blue        = out_ch.blue;
				got.alpha       = out_ch.alpha;
				got.last_of_run = out_ch.last_of_run;
				book.check_pixel(got);
			end
			if (cfg.valid && cfg.ready) begin
				book.set_format(tfr_pkg::fmt_t'(cfg.source_format));
			end
			if (in_ch.valid && in_ch.ready) begin
				book.note_byte(in_ch.data_byte, in_ch.last_byte);
			end
		end
	end

	// Watchdog: any beat on any channel resets the count.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("texel_format_to_rgba32_top_test NOT OK");
				$finish;
			end
		end
	end

	function automatic int bytes_per_pixel(tfr_pkg::fmt_t f);
		case (f)
			tfr_pkg::FMT_RGBA32:                   return 4;
			tfr_pkg::FMT_RGBA16, tfr_pkg::FMT_IA16: return 2;
			default:                               return 1;
		endcase
	endfunction

	// Offers one byte and holds it until the beat. Valid is lowered only
	// when a gap follows, so a back-to-back byte never sees valid drop.
	task automatic send_byte(input logic [7:0] b, input logic last);
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			int gap;
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops sending and waits for every predicted pixel to come out. The
	// first edge lets the byte accepted just before this call be noted.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (book.pending.size() != 0) @(posedge clk);
	endtask

	// A format write only happens with the block idle. Bytes that leave a
	// partial pixel make no output, so a few extra cycles are allowed.
	task automatic write_format(input tfr_pkg::fmt_t f);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg.source_format <= f;
		cfg.valid         <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_fmt = f;
	endtask

	task automatic directed_byte(input tfr_pkg::fmt_t f, input logic [7:0] b,
			input logic last);
		if (f != cur_fmt) begin
			write_format(f);
		end
		send_byte(b, last);
	endtask

	initial begin
		int            len;
		int            sent;
		int            bpp;
		logic          ends;
		tfr_pkg::fmt_t f;

		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.data_byte   <= 8'h00;
		in_ch.last_byte   <= 1'b0;
		cfg.valid         <= 1'b0;
		cfg.source_format <= tfr_pkg::FMT_RGBA32;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The first bytes use the format left by reset.
		// rgba32: one full pass-through pixel, then a partial pixel closed by
		// the last byte, then a lone held byte that the next format write
		// must throw away.
		gaps_on = $urandom_range(0, 1);
		directed_byte(tfr_pkg::FMT_RGBA32, 8'hFF, 1'b0);
		directed_byte(tfr_pkg::FMT_RGBA32, 8'h00, 1'b0);
		directed_byte(tfr_pkg::FMT_RGBA32, 8'hFF, 1'b0);
		directed_byte(tfr_pkg::FMT_RGBA32, 8'h00, 1'b0);
		directed_byte(tfr_pkg::FMT_RGBA32, 8'h12, 1'b0);
		directed_byte(tfr_pkg::FMT_RGBA32, 8'h34, 1'b1);
		directed_byte(tfr_pkg::FMT_RGBA32, 8'hAB, 1'b0);
		// rgba16: all ones, all zeros, then a dropped half pixel.
		directed_byte(tfr_pkg::FMT_RGBA16, 8'hFF, 1'b0);
		directed_byte(tfr_pkg::FMT_RGBA16, 8'hFF, 1'b0);
		directed_byte(tfr_pkg::FMT_RGBA16, 8'h00, 1'b0);
		directed_byte(tfr_pkg::FMT_RGBA16, 8'h00, 1'b0);
		directed_byte(tfr_pkg::FMT_RGBA16, 8'h12, 1'b1);
		// ia1: each bit both ways, eight pixels per byte.
		directed_byte(tfr_pkg::FMT_IA1, 8'hA5, 1'b0);
		directed_byte(tfr_pkg::FMT_IA1, 8'h5A, 1'b1);
		// ia4: top intensity with alpha off, zero intensity with alpha on.
		directed_byte(tfr_pkg::FMT_IA4, 8'hEF, 1'b0);
		directed_byte(tfr_pkg::FMT_IA4, 8'h10, 1'b1);
		directed_byte(tfr_pkg::FMT_IA8, 8'hF0, 1'b0);
		directed_byte(tfr_pkg::FMT_IA8, 8'h0F, 1'b1);
		directed_byte(tfr_pkg::FMT_IA16, 8'hFF, 1'b0);
		directed_byte(tfr_pkg::FMT_IA16, 8'h00, 1'b0);
		directed_byte(tfr_pkg::FMT_IA16, 8'h00, 1'b0);
		directed_byte(tfr_pkg::FMT_IA16, 8'hFF, 1'b1);
		directed_byte(tfr_pkg::FMT_I4, 8'hF0, 1'b0);
		directed_byte(tfr_pkg::FMT_I4, 8'h0F, 1'b1);
		directed_byte(tfr_pkg::FMT_I8, 8'h00, 1'b0);
		directed_byte(tfr_pkg::FMT_I8, 8'hFF, 1'b1);

		// Random part: one format per phase, the two extreme codes first.
		// Most runs are whole pixels, often closed by the last byte; some
		// are cut short so that a partial pixel gets dropped, and a phase
		// may end mid-pixel so that the next write discards it.
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				f = tfr_pkg::FMT_I8;
			end else if (p == 1) begin
				f = tfr_pkg::FMT_RGBA32;
			end else begin
				f = tfr_pkg::fmt_t'(3'($urandom_range(0, 7)));
			end
			write_format(f);
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) == 0) begin
				ready_mask <= 16'hFFFF;
			end else begin
				ready_mask <= 16'($urandom_range(0, 65535)) | 16'h0001;
			end
			bpp  = bytes_per_pixel(f);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				len = bpp * $urandom_range(1, 4);
				if (bpp > 1 && $urandom_range(0, 4) == 0) begin
					len -= $urandom_range(1, bpp - 1);
				end
				ends = ($urandom_range(0, 9) < 7);
				for (int k = 0; k < len; k++) begin
					send_byte(8'($urandom_range(0, 255)), (k == len - 1) && ends);
					sent++;
				end
				// On odd phases the sender holds off halfway until the
				// output side has caught up completely.
				if (p % 2 == 1 && sent >= PHASE_BYTES / 2 && sent - len < PHASE_BYTES / 2) begin
					drain();
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.pending.size() == 0) begin
			$display("texel_format_to_rgba32_top_test OK");
		end else begin
			$display("texel_format_to_rgba32_top_test NOT OK");
		end
		$finish;
	end

endmodule

[texel_format_to_rgba32_top.f]
src/tfr_pkg.sv
src/tfr_if.sv
src/tfr_front.sv
src/tfr_fifo.sv
src/tfr_back.sv
src/texel_format_to_rgba32_top.sv
dv/texel_format_to_rgba32_top_test.sv
